// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion that is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define CARM_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Assertion on the usual clk_i and rst_ni of the enclosing module.
`define CARM_ASSERT(lbl, prop) `CARM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/carm_pkg.sv =====
package carm_pkg;

  // Tick commands.
  localparam logic CMD_ATTITUDE = 1'b0;
  localparam logic CMD_RATE     = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ATT_KP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ATT_KD     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RATE_KP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STICK_SCL  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ACT_LOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ACT_HIGH   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_EN    = 3'd6;

  // round(pi / 180 * 2^32), used with a 32-bit rounding shift.
  localparam logic signed [31:0] DEG2RAD_Q32 = 32'sd74961321;

  localparam logic signed [47:0] S32_MAX_W = 48'sd2147483647;
  localparam logic signed [47:0] S32_MIN_W = -48'sd2147483648;

  // Mixer signs, one bit per motor (bit i for motor i), set where the term is subtracted.
  localparam logic [3:0] MIX_ROLL_NEG  = 4'b0110;
  localparam logic [3:0] MIX_PITCH_NEG = 4'b1100;
  localparam logic [3:0] MIX_YAW_NEG   = 4'b1010;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] roll_stick;
    logic signed [31:0] pitch_stick;
    logic signed [31:0] yaw_stick;
    logic signed [31:0] throttle;
    logic signed [31:0] measured_roll;
    logic signed [31:0] measured_pitch;
    logic signed [31:0] measured_roll_rate;
    logic signed [31:0] measured_pitch_rate;
    logic signed [31:0] gyro_x_dps;
    logic signed [31:0] gyro_y_dps;
    logic signed [31:0] gyro_z_dps;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] motor_front_a;
    logic signed [31:0] motor_front_b;
    logic signed [31:0] motor_rear_a;
    logic signed [31:0] motor_rear_b;
    logic signed [31:0] roll_rate_setpoint;
    logic signed [31:0] pitch_rate_setpoint;
    logic signed [31:0] yaw_rate_setpoint;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_POST  = 5'b00100,
    ST_MIX   = 5'b01000,
    ST_CLAMP = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    A_ROLL_STICK,
    A_PITCH_STICK,
    A_YAW_STICK,
    A_ATT_KP,
    A_ATT_KD,
    A_RATE_KP,
    A_GYRO_X,
    A_GYRO_Y,
    A_GYRO_Z
  } opa_sel_e;

  typedef enum logic [2:0] {
    B_SCALE,
    B_TEMP,
    B_ROLL_RATE,
    B_PITCH_RATE,
    B_DEG2RAD
  } opb_sel_e;

  typedef enum logic [3:0] {
    P_ERR_ROLL,
    P_ERR_PITCH,
    P_NEG,
    P_HOLD,
    P_SP_ROLL,
    P_SP_PITCH,
    P_SP_YAW,
    P_RERR_ROLL,
    P_RERR_PITCH,
    P_RERR_YAW,
    P_ROLL_ACT,
    P_PITCH_ACT,
    P_YAW_ACT
  } post_e;

  typedef struct packed {
    opa_sel_e a_sel;
    opb_sel_e b_sel;
    logic     wide_shift;
    post_e    post;
    logic     last;
  } uop_t;

  // Microprogram of the shared multiplier: one entry per multiply step of each tick.
  function automatic uop_t uop_rom(input logic cmd, input logic [2:0] step);
    uop_t uop;
    case ({cmd, step})
      {CMD_ATTITUDE, 3'd0}: uop = '{A_ROLL_STICK,  B_SCALE,      1'b0, P_ERR_ROLL,   1'b0};
      {CMD_ATTITUDE, 3'd1}: uop = '{A_ATT_KP,      B_TEMP,       1'b0, P_HOLD,       1'b0};
      {CMD_ATTITUDE, 3'd2}: uop = '{A_ATT_KD,      B_ROLL_RATE,  1'b0, P_SP_ROLL,    1'b0};
      {CMD_ATTITUDE, 3'd3}: uop = '{A_PITCH_STICK, B_SCALE,      1'b0, P_ERR_PITCH,  1'b0};
      {CMD_ATTITUDE, 3'd4}: uop = '{A_ATT_KP,      B_TEMP,       1'b0, P_HOLD,       1'b0};
      {CMD_ATTITUDE, 3'd5}: uop = '{A_ATT_KD,      B_PITCH_RATE, 1'b0, P_SP_PITCH,   1'b0};
      {CMD_ATTITUDE, 3'd6}: uop = '{A_YAW_STICK,   B_SCALE,      1'b0, P_NEG,        1'b0};
      {CMD_ATTITUDE, 3'd7}: uop = '{A_ATT_KP,      B_TEMP,       1'b0, P_SP_YAW,     1'b1};
      {CMD_RATE, 3'd0}:     uop = '{A_GYRO_X,      B_DEG2RAD,    1'b1, P_RERR_ROLL,  1'b0};
      {CMD_RATE, 3'd1}:     uop = '{A_RATE_KP,     B_TEMP,       1'b0, P_ROLL_ACT,   1'b0};
      {CMD_RATE, 3'd2}:     uop = '{A_GYRO_Y,      B_DEG2RAD,    1'b1, P_RERR_PITCH, 1'b0};
      {CMD_RATE, 3'd3}:     uop = '{A_RATE_KP,     B_TEMP,       1'b0, P_PITCH_ACT,  1'b0};
      {CMD_RATE, 3'd4}:     uop = '{A_GYRO_Z,      B_DEG2RAD,    1'b1, P_RERR_YAW,   1'b0};
      {CMD_RATE, 3'd5}:     uop = '{A_RATE_KP,     B_TEMP,       1'b0, P_YAW_ACT,    1'b1};
      default:              uop = '{A_ROLL_STICK,  B_SCALE,      1'b0, P_HOLD,       1'b1};
    endcase
    return uop;
  endfunction

endpackage

// ===== hw/rtl/cascaded_attitude_rate_mixer_unit.sv =====
// Cascaded attitude and rate controller for a quad X frame, Q16.16 fixed point. A command 0
// beat (attitude tick) turns the scaled sticks, measured angles and measured rates into roll,
// pitch and yaw rate setpoints by a PD law (P only on yaw) and stores them. A command 1 beat
// (rate tick) runs a P law on the stored setpoints minus the gyro rates, converted from deg/s
// to rad/s, and mixes four motor commands. Every beat, enabled or not, clamps the stored motor
// commands to the actuator limits and returns one result beat with the motors (zero while the
// loop is disabled) and the setpoints. All multiplies go through one 32x32 signed multiplier
// followed by a rounding shift and saturation, sequenced by a small microprogram: each multiply
// step has a multiply state and then a state that rounds, saturates and combines. An attitude
// tick is eight steps plus the clamp state; a rate tick is six steps, four mixer steps (one
// motor sum per cycle) and the clamp state; a disabled tick takes only the clamp state. The
// input is ready again in the cycle after the clamp state, and no new beat is taken while a
// tick is in progress. The result sits in an output register, so the next beat can be taken
// while it waits; the clamp state holds only if the previous result has not yet been taken.
// Configuration writes are always ready and land in the next cycle; out-of-range indexes are
// ignored. Write configuration only while the block is idle.
`include "assert_macros.svh"

module cascaded_attitude_rate_mixer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  carm_pkg::in_beat_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output carm_pkg::out_beat_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [carm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import carm_pkg::*;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [47:0] diff;
    diff = 48'(a) - 48'(b);
    return sat48(diff);
  endfunction

  // Configuration registers.
  logic        [30:0] att_kp_q, att_kd_q, rate_kp_q, stick_scl_q;
  logic signed [31:0] act_low_q, act_high_q;
  logic               loop_en_q;

  // Sequencer and datapath state.
  state_e             state_q, state_d;
  logic        [2:0]  step_q, step_d;
  logic        [1:0]  mix_q, mix_d;
  in_beat_t           item_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] tmp_q, tmp_d;
  logic signed [31:0] hold_q, hold_d;
  logic signed [31:0] roll_act_q, roll_act_d;
  logic signed [31:0] pitch_act_q, pitch_act_d;
  logic signed [31:0] yaw_act_q, yaw_act_d;
  logic signed [31:0] sp_q [3];
  logic signed [31:0] sp_d [3];
  logic signed [31:0] motor_q [4];
  logic signed [31:0] motor_d [4];
  logic signed [31:0] clamped [4];
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  uop_t               uop;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_rnd;
  logic signed [47:0] prod_shr;
  logic signed [31:0] res;
  logic signed [32:0] roll_half_w, pitch_half_w;
  logic signed [31:0] roll_half, pitch_half;
  logic signed [47:0] mix_sum;
  logic               in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign uop = uop_rom(item_q.cmd, step_q);

  // Operand selection for the shared multiplier. Gains are non-negative and fit a signed word.
  always_comb begin
    case (uop.a_sel)
      A_ROLL_STICK:  opa = item_q.roll_stick;
      A_PITCH_STICK: opa = item_q.pitch_stick;
      A_YAW_STICK:   opa = item_q.yaw_stick;
      A_ATT_KP:      opa = $signed({1'b0, att_kp_q});
      A_ATT_KD:      opa = $signed({1'b0, att_kd_q});
      A_RATE_KP:     opa = $signed({1'b0, rate_kp_q});
      A_GYRO_X:      opa = item_q.gyro_x_dps;
      A_GYRO_Y:      opa = item_q.gyro_y_dps;
      A_GYRO_Z:      opa = item_q.gyro_z_dps;
      default:       opa = '0;
    endcase
    case (uop.b_sel)
      B_SCALE:      opb = $signed({1'b0, stick_scl_q});
      B_TEMP:       opb = tmp_q;
      B_ROLL_RATE:  opb = item_q.measured_roll_rate;
      B_PITCH_RATE: opb = item_q.measured_pitch_rate;
      B_DEG2RAD:    opb = DEG2RAD_Q32;
      default:      opb = '0;
    endcase
  end

  // Rounding shift, half toward plus infinity, then saturation.
  always_comb begin
    if (uop.wide_shift) begin
      prod_rnd = prod_q + 64'sh8000_0000;
      prod_shr = 48'(prod_rnd >>> 32);
    end else begin
      prod_rnd = prod_q + 64'sh8000;
      prod_shr = 48'(prod_rnd >>> 16);
    end
    res = sat48(prod_shr);
  end

  // Half of the roll and pitch terms, rounded half up; this never overflows a word.
  assign roll_half_w  = ($signed({roll_act_q[31], roll_act_q}) + 33'sd1) >>> 1;
  assign pitch_half_w = ($signed({pitch_act_q[31], pitch_act_q}) + 33'sd1) >>> 1;
  assign roll_half    = roll_half_w[31:0];
  assign pitch_half   = pitch_half_w[31:0];

  // One motor sum per cycle, formed exactly and saturated once.
  always_comb begin
    mix_sum = 48'(item_q.throttle);
    mix_sum = MIX_ROLL_NEG[mix_q]  ? mix_sum - 48'(roll_half)  : mix_sum + 48'(roll_half);
    mix_sum = MIX_PITCH_NEG[mix_q] ? mix_sum - 48'(pitch_half) : mix_sum + 48'(pitch_half);
    mix_sum = MIX_YAW_NEG[mix_q]   ? mix_sum - 48'(yaw_act_q)  : mix_sum + 48'(yaw_act_q);
  end

  // With inverted limits, a value above the upper limit takes it and any other value takes the lower one.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (motor_q[i] > act_high_q) begin
        clamped[i] = act_high_q;
      end else if (motor_q[i] < act_low_q) begin
        clamped[i] = act_low_q;
      end else begin
        clamped[i] = motor_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    mix_d       = mix_q;
    tmp_d       = tmp_q;
    hold_d      = hold_q;
    roll_act_d  = roll_act_q;
    pitch_act_d = pitch_act_q;
    yaw_act_d   = yaw_act_q;
    sp_d        = sp_q;
    motor_d     = motor_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          step_d  = '0;
          state_d = loop_en_q ? ST_MUL : ST_CLAMP;
        end
      end
      ST_MUL: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        case (uop.post)
          P_ERR_ROLL:   tmp_d = sub_sat(res, item_q.measured_roll);
          P_ERR_PITCH:  tmp_d = sub_sat(sub_sat(32'sd0, res), item_q.measured_pitch);
          P_NEG:        tmp_d = sub_sat(32'sd0, res);
          P_HOLD:       hold_d = res;
          P_SP_ROLL:    sp_d[0] = sub_sat(hold_q, res);
          P_SP_PITCH:   sp_d[1] = sub_sat(hold_q, res);
          P_SP_YAW:     sp_d[2] = res;
          P_RERR_ROLL:  tmp_d = sub_sat(sp_q[0], res);
          P_RERR_PITCH: tmp_d = sub_sat(sp_q[1], res);
          P_RERR_YAW:   tmp_d = sub_sat(sp_q[2], res);
          P_ROLL_ACT:   roll_act_d = res;
          P_PITCH_ACT:  pitch_act_d = res;
          P_YAW_ACT:    yaw_act_d = sat48(48'(res) + 48'(res));
          default:      hold_d = hold_q;
        endcase
        step_d = step_q + 3'd1;
        if (uop.last) begin
          mix_d   = '0;
          state_d = (item_q.cmd == CMD_RATE) ? ST_MIX : ST_CLAMP;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MIX: begin
        motor_d[mix_q] = sat48(mix_sum);
        mix_d          = mix_q + 2'd1;
        if (mix_q == 2'd3) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid_q || out_ready_i) begin
          motor_d                   = clamped;
          out_valid_d               = 1'b1;
          out_d.motor_front_a       = loop_en_q ? clamped[0] : 32'sd0;
          out_d.motor_front_b       = loop_en_q ? clamped[1] : 32'sd0;
          out_d.motor_rear_a        = loop_en_q ? clamped[2] : 32'sd0;
          out_d.motor_rear_b        = loop_en_q ? clamped[3] : 32'sd0;
          out_d.roll_rate_setpoint  = sp_q[0];
          out_d.pitch_rate_setpoint = sp_q[1];
          out_d.yaw_rate_setpoint   = sp_q[2];
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_kp_q    <= '0;
      att_kd_q    <= '0;
      rate_kp_q   <= '0;
      stick_scl_q <= 31'd65536;
      act_low_q   <= 32'sd0;
      act_high_q  <= 32'sd65536;
      loop_en_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ATT_KP:    att_kp_q    <= cfg_data_i[30:0];
        CFG_ATT_KD:    att_kd_q    <= cfg_data_i[30:0];
        CFG_RATE_KP:   rate_kp_q   <= cfg_data_i[30:0];
        CFG_STICK_SCL: stick_scl_q <= cfg_data_i[30:0];
        CFG_ACT_LOW:   act_low_q   <= $signed(cfg_data_i);
        CFG_ACT_HIGH:  act_high_q  <= $signed(cfg_data_i);
        CFG_LOOP_EN:   loop_en_q   <= cfg_data_i[0];
        default:       loop_en_q   <= loop_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mix_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sp_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        motor_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      mix_q       <= mix_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      motor_q     <= motor_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= opa * opb;
    end
    tmp_q       <= tmp_d;
    hold_q      <= hold_d;
    roll_act_q  <= roll_act_d;
    pitch_act_q <= pitch_act_d;
    yaw_act_q   <= yaw_act_d;
    out_q       <= out_d;
  end

  // The input is not ready in the cycle after a beat is accepted.
  `CARM_ASSERT(a_busy_after_accept, in_fire |=> !in_ready_o)
  // The microprogram of a rate tick ends after six steps.
  `CARM_ASSERT(a_rate_step_bound,
      (state_q == ST_POST) && (item_q.cmd == CMD_RATE) |-> step_q <= 3'd5)
  // The clamp cycle holds while an untaken result sits in the output register.
  `CARM_ASSERT(a_clamp_waits,
      (state_q == ST_CLAMP) && out_valid_q && !out_ready_i |=> state_q == ST_CLAMP)
  // With sane limits, the front-a and rear-b motors of an enabled result stay within them.
  `CARM_ASSERT(a_motor_in_limits,
      out_valid_o && loop_en_q && (act_low_q <= act_high_q) |->
      ($signed(out_data_o.motor_front_a) <= act_high_q) &&
      ($signed(out_data_o.motor_front_a) >= act_low_q) &&
      ($signed(out_data_o.motor_rear_b) <= act_high_q) &&
      ($signed(out_data_o.motor_rear_b) >= act_low_q))

endmodule
